FILE: src/char_lcd_nibble_interface_top_assert.svh
// Assertion macros shared by the nibble interface RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_TOP_ASSERT_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_TOP_ASSERT_SVH

// Checked only outside reset.
`define CLN_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checked at every edge, reset included.
`define CLN_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) \
        else $error(msg);

`endif

FILE: src/cln_pkg.sv
// Package for the character LCD nibble interface: request kinds, states,
// LCD command bytes and the sequencer-to-nibble-unit command struct. No deps.
`default_nettype none

package cln_pkg;

    localparam int COLUMNS_DEF = 16;
    localparam int COLUMNS_MAX = 40;
    // Strobe index width: up to 2 + 2*COLUMNS_MAX strobes per request
    localparam int STEP_W      = $clog2(2 * COLUMNS_MAX + 2);

    typedef enum logic [2:0] {
        KIND_CHAR    = 3'd0,
        KIND_INSTR   = 3'd1,
        KIND_MOVE    = 3'd2,
        KIND_CLRPOS  = 3'd3,
        KIND_CLRDISP = 3'd4,
        KIND_STARTUP = 3'd5
    } req_kind_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } seq_state_t;

    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0F;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;
    localparam logic [6:0] WAIT_SHORT    = 7'd5;
    localparam logic [6:0] WAIT_LONG     = 7'd100;
    localparam int         STARTUP_NIBS  = 4;
    localparam int         STARTUP_LAST  = 9;

    typedef struct packed {
        logic              valid;
        req_kind_t         kind;
        logic [7:0]        data_byte;
        logic [6:0]        addr;
        logic [STEP_W-1:0] step;
        logic              last;
        logic              rs;
    } nib_cmd_t;

endpackage

`default_nettype wire

FILE: src/cln_req_if.sv
// Request channel of the nibble interface: valid/ready plus request fields.
// No dependencies.
`default_nettype none

interface cln_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       row;
    logic [3:0] column;

    modport source (output valid, req_type, data_byte, row, column, input ready);
    modport sink   (input valid, req_type, data_byte, row, column, output ready);
endinterface

`default_nettype wire

FILE: src/cln_nib_if.sv
// Nibble result channel: valid/ready plus one strobed nibble.
// No dependencies.
`default_nettype none

interface cln_nib_if;
    logic       valid;
    logic       ready;
    logic [3:0] nibble;
    logic       reg_select;
    logic [6:0] extra_wait_ms;
    logic       last;

    modport source (output valid, nibble, reg_select, extra_wait_ms, last, input ready);
    modport sink   (input valid, nibble, reg_select, extra_wait_ms, last, output ready);
endinterface

`default_nettype wire

FILE: src/cln_seq.sv
// Request sequencer: takes a request, counts strobes, tracks the RS level.
// Depends on cln_pkg, cln_req_if and the assertion macro header.
`default_nettype none
`include "char_lcd_nibble_interface_top_assert.svh"

module cln_seq #(
    parameter int COLUMNS = cln_pkg::COLUMNS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    cln_req_if.sink                req,
    input  wire logic              take,
    output cln_pkg::nib_cmd_t      cmd
);
    import cln_pkg::*;

    localparam logic [STEP_W-1:0] COLS_W = STEP_W'(COLUMNS);

    seq_state_t        state_reg, state_next;
    req_kind_t         kind_reg, kind_next;
    logic [7:0]        data_reg, data_next;
    logic [6:0]        addr_reg, addr_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] last_idx_reg, last_idx_next;
    logic              rs_level_reg, rs_level_next;
    logic [STEP_W-1:0] col_ext;
    logic              accept;

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign col_ext   = STEP_W'(req.column);

    always_comb
    begin
        state_next    = state_reg;
        kind_next     = kind_reg;
        data_next     = data_reg;
        addr_next     = addr_reg;
        step_next     = step_reg;
        last_idx_next = last_idx_reg;
        rs_level_next = rs_level_reg;
        if (accept)
        begin
            kind_next = req_kind_t'(req.req_type);
            data_next = req.data_byte;
            // row*0x40 + column
            addr_next = {req.row, 2'b00, req.column};
            step_next = '0;
            case (req.req_type) inside
                KIND_CHAR:
                begin
                    state_next    = ST_RUN;
                    last_idx_next = STEP_W'(1);
                end
                KIND_INSTR, KIND_MOVE, KIND_CLRDISP:
                begin
                    state_next    = ST_RUN;
                    last_idx_next = STEP_W'(1);
                    rs_level_next = 1'b1;
                end
                KIND_CLRPOS:
                begin
                    state_next    = ST_RUN;
                    rs_level_next = 1'b1;
                    if (col_ext < COLS_W)
                        last_idx_next = STEP_W'(((COLS_W - col_ext) << 1) + 1'b1);
                    else
                        last_idx_next = STEP_W'(1);
                end
                KIND_STARTUP:
                begin
                    state_next    = ST_RUN;
                    rs_level_next = 1'b1;
                    last_idx_next = STEP_W'(STARTUP_LAST);
                end
                default:
                begin
                    // unused kinds: dropped, nothing emitted
                    state_next = ST_IDLE;
                end
            endcase
        end
        else if (state_reg == ST_RUN && take)
        begin
            if (step_reg == last_idx_reg)
                state_next = ST_IDLE;
            else
                step_next = STEP_W'(step_reg + 1'b1);
        end
    end

    always_comb
    begin
        cmd.valid     = (state_reg == ST_RUN);
        cmd.kind      = kind_reg;
        cmd.data_byte = data_reg;
        cmd.addr      = addr_reg;
        cmd.step      = step_reg;
        cmd.last      = (step_reg == last_idx_reg);
        cmd.rs        = rs_level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            last_idx_reg <= '0;
            rs_level_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            last_idx_reg <= last_idx_next;
            rs_level_reg <= rs_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        data_reg <= data_next;
        addr_reg <= addr_next;
    end

    `CLN_ASSERT(a_last_goes_idle,
        (state_reg == ST_RUN && take && step_reg == last_idx_reg) |=> state_reg == ST_IDLE,
        "sequencer did not return to idle after the last strobe")
    `CLN_ASSERT(a_step_in_range,
        state_reg == ST_RUN |-> step_reg <= last_idx_reg,
        "strobe index ran past the end of the request")
    `CLN_ASSERT(a_take_only_running,
        take |-> state_reg == ST_RUN,
        "nibble unit took a strobe while the sequencer was idle")

endmodule

`default_nettype wire

FILE: src/cln_nib.sv
// Shared nibble unit: picks byte and half for the current strobe, holds the
// result in the output register. Depends on cln_pkg, cln_nib_if, macro header.
`default_nettype none
`include "char_lcd_nibble_interface_top_assert.svh"

module cln_nib (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  cln_pkg::nib_cmd_t  cmd,
    output logic               take,
    cln_nib_if.source          rsp
);
    import cln_pkg::*;

    logic       valid_reg, valid_next;
    logic [3:0] nibble_reg;
    logic       rs_reg;
    logic [6:0] wait_reg;
    logic       last_reg;

    logic [7:0] byte_sel;
    logic [7:0] move_byte;
    logic [3:0] nib_sel;
    logic       rs_sel;
    logic [6:0] wait_sel;
    logic       single;
    logic [STEP_W-1:0] init_idx;

    assign take      = cmd.valid && (!valid_reg || rsp.ready);
    assign move_byte = CMD_SET_DDRAM | {1'b0, cmd.addr};
    assign init_idx  = STEP_W'((cmd.step - STEP_W'(STARTUP_NIBS)) >> 1);

    always_comb
    begin
        byte_sel = cmd.data_byte;
        rs_sel   = 1'b0;
        wait_sel = '0;
        single   = 1'b0;
        nib_sel  = NIB_WAKE;
        case (cmd.kind)
            KIND_CHAR:    rs_sel = cmd.rs;
            KIND_INSTR:   byte_sel = cmd.data_byte;
            KIND_MOVE:    byte_sel = move_byte;
            KIND_CLRDISP: byte_sel = CMD_CLEAR;
            KIND_CLRPOS:
            begin
                if (cmd.step < STEP_W'(2))
                    byte_sel = move_byte;
                else
                begin
                    byte_sel = CHAR_SPACE;
                    rs_sel   = 1'b1;
                end
            end
            KIND_STARTUP:
            begin
                if (cmd.step < STEP_W'(STARTUP_NIBS))
                begin
                    // wake-up nibbles 3,3,3 then switch to 4-bit mode
                    single = 1'b1;
                    if (cmd.step == STEP_W'(STARTUP_NIBS - 1))
                        nib_sel = NIB_FOUR_BIT;
                    if (cmd.step == '0 || cmd.step == STEP_W'(STARTUP_NIBS - 1))
                        wait_sel = WAIT_SHORT;
                    else
                        wait_sel = WAIT_LONG;
                end
                else
                begin
                    case (init_idx)
                        STEP_W'(0): byte_sel = CMD_ENTRY;
                        STEP_W'(1): byte_sel = CMD_DISP_ON;
                        default:    byte_sel = CMD_CLEAR;
                    endcase
                end
            end
            default:      byte_sel = cmd.data_byte;
        endcase
        if (!single)
            nib_sel = cmd.step[0] ? byte_sel[3:0] : byte_sel[7:4];
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            nibble_reg <= nib_sel;
            rs_reg     <= rs_sel;
            wait_reg   <= wait_sel;
            last_reg   <= cmd.last;
        end
    end

    assign rsp.valid         = valid_reg;
    assign rsp.nibble        = nibble_reg;
    assign rsp.reg_select    = rs_reg;
    assign rsp.extra_wait_ms = wait_reg;
    assign rsp.last          = last_reg;

    `CLN_ASSERT(a_wait_only_instr,
        (rsp.valid && rsp.extra_wait_ms != 7'd0) |-> !rsp.reg_select,
        "start-up pause on a data strobe")
    `CLN_ASSERT(a_wait_only_startup,
        (take && cmd.kind != KIND_STARTUP) |=> rsp.extra_wait_ms == 7'd0,
        "extra pause outside start-up")
    `CLN_ASSERT_ALWAYS(a_reset_empty,
        !rst_n |=> !valid_reg,
        "output register holds a strobe during reset")

endmodule

`default_nettype wire

FILE: src/char_lcd_nibble_interface_top.sv
// Character LCD 4-bit interface. A request of N strobes holds off the next one
// until its last nibble is in the output register; one nibble per cycle enters
// it while the receiver does not stall. N is 2 for byte requests, 10 for start-up,
// 2 + 2*(COLUMNS-column) for clear from position (2 when column is past the end);
// unused kinds emit none. First nibble passes the state and output registers.
// Async active-low reset empties the output register and sets RS level to 0.
`default_nettype none

module char_lcd_nibble_interface_top #(
    parameter int COLUMNS = cln_pkg::COLUMNS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    cln_req_if.sink   req,
    cln_nib_if.source rsp
);
    import cln_pkg::*;

    // Sequencer -> nibble unit: strobe description for the current step.
    nib_cmd_t cmd;
    // Nibble unit -> sequencer: the output register took this strobe.
    logic     take;

    // Sequencer owns the request: kind, byte, cursor address, strobe index
    // and the sticky RS level (set once any instruction request is accepted).
    cln_seq #(
        .COLUMNS (COLUMNS)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .take  (take),
        .cmd   (cmd)
    );

    // One shared selection unit turns (kind, step) into nibble, RS and pause;
    // its output register decouples the sink so a stalled nibble holds.
    cln_nib u_nib (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .take  (take),
        .rsp   (rsp)
    );

endmodule

`default_nettype wire

FILE: verif/tb_char_lcd_nibble_interface_top.sv
// Self-checking testbench for char_lcd_nibble_interface_top.
// Needs cln_pkg, cln_req_if, cln_nib_if and the top module from src.
`default_nettype none

module tb_char_lcd_nibble_interface_top;
    import cln_pkg::*;

    localparam int LCD_COLS     = 16;
    localparam int QUIET_LIMIT  = 3000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES  = 300;    // long receiver stall
    localparam int TAIL_CYCLES  = 40;     // tail after the final drain, for stray strobes
    localparam int PHASE_ITEMS  = 60;

    // Request kinds the block has no use for; it must drop them silently
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [3:0] nibble;
        logic       rs;
        logic [6:0] wait_ms;
        logic       last;
    } strobe_t;

    // One row of the directed table; byte_exp/rs_exp only used when typed is set
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic       row;
        logic [3:0] col;
        logic       typed;
        logic [7:0] byte_exp;
        logic       rs_exp;
    } dir_row_t;

    logic clk;
    logic rst_n;

    cln_req_if req_ch ();
    cln_nib_if nib_ch ();

    char_lcd_nibble_interface_top #(
        .COLUMNS(LCD_COLS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (nib_ch)
    );

    strobe_t  expected_strobes [$];   // strobes still owed by the block, oldest first
    strobe_t  new_strobes [$];        // strobes of the request just accepted
    strobe_t  head_strobe;
    logic     lcd_rs_level;           // predicted RS level
    dir_row_t directed_rows [21];

    int fail_count;
    int quiet_cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    int rx_hold_left;
    bit rx_hold_arm;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void add_strobe(logic [3:0] nib, logic rs, logic [6:0] wait_ms);
        strobe_t s;
        s.nibble  = nib;
        s.rs      = rs;
        s.wait_ms = wait_ms;
        s.last    = 1'b0;
        new_strobes.push_back(s);
    endfunction

    // A byte always goes out high nibble first
    function automatic void add_byte(logic [7:0] b, logic rs);
        add_strobe(b[7:4], rs, 7'd0);
        add_strobe(b[3:0], rs, 7'd0);
    endfunction

    // Instructions go out with RS low and leave the RS level high
    function automatic void add_instr(logic [7:0] b);
        add_byte(b, 1'b0);
        lcd_rs_level = 1'b1;
    endfunction

    function automatic void predict_strobes(logic [2:0] kind, logic [7:0] data,
                                            logic row, logic [3:0] col);
        logic [7:0] cursor_cmd;
        int         c;
        new_strobes.delete();
        // DDRAM address: row selects bit 6, column the low bits
        cursor_cmd = CMD_SET_DDRAM | {1'b0, row, 2'b00, col};
        case (kind)
            KIND_CHAR:    add_byte(data, lcd_rs_level);
            KIND_INSTR:   add_instr(data);
            KIND_MOVE:    add_instr(cursor_cmd);
            KIND_CLRPOS:
            begin
                add_instr(cursor_cmd);
                for (c = int'(col); c < LCD_COLS; c++)
                    add_byte(CHAR_SPACE, lcd_rs_level);
            end
            KIND_CLRDISP: add_instr(CMD_CLEAR);
            KIND_STARTUP:
            begin
                // four single wake-up nibbles, then the init instructions
                lcd_rs_level = 1'b0;
                add_strobe(NIB_WAKE,     1'b0, WAIT_SHORT);
                add_strobe(NIB_WAKE,     1'b0, WAIT_LONG);
                add_strobe(NIB_WAKE,     1'b0, WAIT_LONG);
                add_strobe(NIB_FOUR_BIT, 1'b0, WAIT_SHORT);
                lcd_rs_level = 1'b1;
                add_instr(CMD_ENTRY);
                add_instr(CMD_DISP_ON);
                add_instr(CMD_CLEAR);
            end
            default: ;   // spare kinds: nothing sent, state kept
        endcase
        if (new_strobes.size() > 0)
            new_strobes[new_strobes.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one request per call, valid left high after acceptance so
    // back-to-back requests never toggle it within one step.
    // ------------------------------------------------------------------
    task automatic send_req(logic [2:0] kind, logic [7:0] data, logic row, logic [3:0] col,
                            logic typed, logic [7:0] byte_exp, logic rs_exp);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.data_byte <= data;
        req_ch.row       <= row;
        req_ch.column    <= col;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // accepted at this edge: state always follows the predictor
        predict_strobes(kind, data, row, col);
        if (typed)
        begin
            new_strobes.delete();
            add_byte(byte_exp, rs_exp);
            new_strobes[1].last = 1'b1;
        end
        foreach (new_strobes[i])
            expected_strobes.push_back(new_strobes[i]);
    endtask

    task automatic random_request(output bit counted);
        int         pick;
        logic [2:0] kind;
        pick = $urandom_range(99);
        if (pick < 30)      kind = KIND_CHAR;
        else if (pick < 45) kind = KIND_INSTR;
        else if (pick < 60) kind = KIND_MOVE;
        else if (pick < 72) kind = KIND_CLRPOS;
        else if (pick < 82) kind = KIND_CLRDISP;
        else if (pick < 90) kind = KIND_STARTUP;
        else                kind = ($urandom_range(1) != 0) ? KIND_SPARE_7 : KIND_SPARE_6;
        send_req(kind, 8'($urandom_range(255)), 1'($urandom_range(1)),
                 4'($urandom_range(15)), 1'b0, 8'h00, 1'b0);
        counted = (kind <= KIND_STARTUP);
    endtask

    // Sender pause: valid low until the block has delivered everything
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_strobes.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random ready, plus one long hold counted here
    // ------------------------------------------------------------------
    initial
    begin
        nib_ch.ready = 1'b0;
        rx_hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                nib_ch.ready <= 1'b0;
            else if (rx_hold_arm)
            begin
                rx_hold_arm  = 1'b0;
                rx_hold_left = HOLD_CYCLES;
                nib_ch.ready <= 1'b0;
            end
            else if (rx_hold_left > 0)
            begin
                rx_hold_left = rx_hold_left - 1;
                nib_ch.ready <= 1'b0;
            end
            else
                nib_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check: every accepted strobe against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && nib_ch.valid && nib_ch.ready)
        begin
            if (expected_strobes.size() == 0)
            begin
                $error("unexpected strobe: nibble %h rs %b wait %0d last %b",
                       nib_ch.nibble, nib_ch.reg_select, nib_ch.extra_wait_ms, nib_ch.last);
                fail_count++;
            end
            else
            begin
                head_strobe = expected_strobes.pop_front();
                if (nib_ch.nibble !== head_strobe.nibble)
                begin
                    $error("nibble: expected %h, got %h", head_strobe.nibble, nib_ch.nibble);
                    fail_count++;
                end
                if (nib_ch.reg_select !== head_strobe.rs)
                begin
                    $error("reg_select: expected %b, got %b", head_strobe.rs, nib_ch.reg_select);
                    fail_count++;
                end
                if (nib_ch.extra_wait_ms !== head_strobe.wait_ms)
                begin
                    $error("extra_wait_ms: expected %0d, got %0d",
                           head_strobe.wait_ms, nib_ch.extra_wait_ms);
                    fail_count++;
                end
                if (nib_ch.last !== head_strobe.last)
                begin
                    $error("last: expected %b, got %b", head_strobe.last, nib_ch.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long without any handshake on either side
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (nib_ch.valid && nib_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        int phase;
        int phase_count;
        bit counted;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = KIND_CHAR;
        req_ch.data_byte = 8'h00;
        req_ch.row       = 1'b0;
        req_ch.column    = 4'd0;
        lcd_rs_level     = 1'b0;
        fail_count       = 0;
        quiet_cycles     = 0;
        rx_hold_arm      = 1'b0;
        tx_idle_pct      = 29;
        rx_idle_pct      = 62;

        // kind, data, row, col, typed, expected byte, expected RS
        directed_rows = '{
            '{KIND_CHAR,    8'h41, 1'b0, 4'd0,  1'b1, 8'h41, 1'b0},  // char before start-up
            '{KIND_CHAR,    8'h00, 1'b0, 4'd0,  1'b1, 8'h00, 1'b0},
            '{KIND_CHAR,    8'hFF, 1'b1, 4'd15, 1'b1, 8'hFF, 1'b0},
            '{KIND_SPARE_6, 8'h00, 1'b0, 4'd0,  1'b0, 8'h00, 1'b0},  // ignored kind
            '{KIND_SPARE_7, 8'hFF, 1'b1, 4'd15, 1'b0, 8'h00, 1'b0},  // ignored kind
            '{KIND_STARTUP, 8'h00, 1'b0, 4'd0,  1'b0, 8'h00, 1'b0},
            '{KIND_CHAR,    8'h00, 1'b0, 4'd0,  1'b1, 8'h00, 1'b1},
            '{KIND_CHAR,    8'hFF, 1'b0, 4'd0,  1'b1, 8'hFF, 1'b1},
            '{KIND_INSTR,   8'h00, 1'b0, 4'd0,  1'b1, 8'h00, 1'b0},
            '{KIND_INSTR,   8'hFF, 1'b1, 4'd15, 1'b1, 8'hFF, 1'b0},
            '{KIND_MOVE,    8'h00, 1'b0, 4'd0,  1'b1, 8'h80, 1'b0},
            '{KIND_MOVE,    8'hFF, 1'b1, 4'd15, 1'b1, 8'hCF, 1'b0},
            '{KIND_MOVE,    8'h00, 1'b1, 4'd0,  1'b1, 8'hC0, 1'b0},
            '{KIND_MOVE,    8'h00, 1'b0, 4'd15, 1'b1, 8'h8F, 1'b0},
            '{KIND_CLRDISP, 8'hFF, 1'b0, 4'd0,  1'b1, 8'h01, 1'b0},
            '{KIND_CLRPOS,  8'h00, 1'b0, 4'd15, 1'b0, 8'h00, 1'b0},  // one space
            '{KIND_CLRPOS,  8'h00, 1'b1, 4'd0,  1'b0, 8'h00, 1'b0},  // longest request
            '{KIND_CLRPOS,  8'hA5, 1'b0, 4'd8,  1'b0, 8'h00, 1'b0},
            '{KIND_CHAR,    8'hA5, 1'b0, 4'd0,  1'b1, 8'hA5, 1'b1},
            '{KIND_STARTUP, 8'hFF, 1'b1, 4'd15, 1'b0, 8'h00, 1'b0},  // start-up again
            '{KIND_CHAR,    8'h5A, 1'b0, 4'd0,  1'b1, 8'h5A, 1'b1}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < $size(directed_rows); k++)
            send_req(directed_rows[k].kind, directed_rows[k].data, directed_rows[k].row,
                     directed_rows[k].col, directed_rows[k].typed,
                     directed_rows[k].byte_exp, directed_rows[k].rs_exp);
        drain();

        // Random part in three idling phases; the first opens with a long
        // receiver hold while requests keep coming, so the input backs up.
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0: begin tx_idle_pct = 29; rx_idle_pct = 62; end
                1: begin tx_idle_pct = 62; rx_idle_pct = 29; end
                default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
            endcase
            if (phase == 0)
                rx_hold_arm = 1'b1;
            phase_count = 0;
            while (phase_count < PHASE_ITEMS)
            begin
                random_request(counted);
                if (counted)
                    phase_count++;
            end
            drain();
        end

        // Everything delivered; give stray strobes a chance to show up
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_strobes.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

`default_nettype wire
